### hdl/lpm_pkg.sv
// Shared types, codes and helpers for the longest prefix match forwarder.
package lpm_pkg;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_FWD = 1'b1;

  localparam logic [1:0] ST_ADDED     = 2'd0;
  localparam logic [1:0] ST_FORWARDED = 2'd1;
  localparam logic [1:0] ST_NO_ROUTE  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [5:0] MAX_LEN = 6'd32;

  typedef struct packed {
    logic        func;
    logic [31:0] address;
    logic [5:0]  prefix_length;
    logic [7:0]  port_number;
  } lpm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_port;
    logic [5:0]  match_length;
    logic [31:0] packets_seen;
  } lpm_out_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  length;
    logic [7:0]  port;
  } lpm_route_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic        found;
    logic [5:0]  len;
    logic [7:0]  port;
    logic [31:0] packets;
  } lpm_tok_t;

  function automatic logic [31:0] len_to_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else if (len >= MAX_LEN) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = 32'hFFFF_FFFF << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

### hdl/lpm_cell.sv
// One route table cell: holds an entry and updates the passing search token.
module lpm_cell
  import lpm_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             live_i,
  input  logic [IDX_W-1:0] my_idx_i,
  input  logic             we_i,
  input  lpm_route_t       wr_i,
  input  logic             upd_i,
  input  logic [31:0]      upd_packets_i,
  input  lpm_tok_t         tok_i,
  input  logic [IDX_W-1:0] tok_idx_i,
  output lpm_tok_t         tok_o,
  output logic [IDX_W-1:0] tok_idx_o
);

  logic [31:0]      prefix_r;
  logic [5:0]       length_r;
  logic [7:0]       port_r;
  logic [31:0]      packets_r;
  lpm_tok_t         tok_r, tok_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             hit;

  always_ff @(posedge clk) begin
    if (we_i) begin
      prefix_r  <= wr_i.prefix;
      length_r  <= wr_i.length;
      port_r    <= wr_i.port;
      packets_r <= 32'h0;
    end else if (upd_i) begin
      packets_r <= upd_packets_i;
    end
  end

  always_comb begin
    hit = live_i && (((tok_i.addr ^ prefix_r) & len_to_mask(length_r)) == 32'h0)
          && (!tok_i.found || (length_r > tok_i.len));
    tok_nxt = tok_i;
    idx_nxt = tok_idx_i;
    if (hit) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.len     = length_r;
      tok_nxt.port    = port_r;
      tok_nxt.packets = packets_r;
      idx_nxt         = my_idx_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.addr    <= tok_nxt.addr;
    tok_r.found   <= tok_nxt.found;
    tok_r.len     <= tok_nxt.len;
    tok_r.port    <= tok_nxt.port;
    tok_r.packets <= tok_nxt.packets;
    idx_r         <= idx_nxt;
  end

  assign tok_o     = tok_r;
  assign tok_idx_o = idx_r;

endmodule

### hdl/longest_prefix_match_forwarder.sv
// Top level: IPv4 route table as a chain of cells with longest prefix lookup.
//
//  channel | ports                      | transfer when
//  --------+----------------------------+-------------------------------
//  input   | start, busy, in_data       | start high and busy low
//  result  | out_valid, out_data        | out_valid high, one cycle
//
// An add gives its result in the cycle after the transfer and leaves busy low.
// A forward walks the cell chain one cell per cycle and gives its result
// from the output register after the last cell; busy is high until then.
// Reset empties the table and drops any search in flight.
// The receiver cannot stall; each result is shown for one cycle.
module longest_prefix_match_forwarder
  import lpm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lpm_in_t  in_data,
  output logic     out_valid,
  output lpm_out_t out_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                busy_r, busy_nxt;
  logic                out_valid_r, out_valid_nxt;
  lpm_out_t            out_data_r, out_data_nxt;
  logic                accept, add_go, fwd_go, full;
  lpm_route_t          wr_route;
  lpm_tok_t            tok_w [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]    idx_w [0:TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] live, we, upd;
  logic [31:0]         pkt_inc;
  lpm_tok_t            tail;

  assign accept = start && !busy_r;
  assign add_go = accept && (in_data.func == FUNC_ADD);
  assign fwd_go = accept && (in_data.func == FUNC_FWD);
  assign full   = (count_r == CNT_W'(TABLE_ENTRIES));

  assign wr_route.prefix = in_data.address;
  assign wr_route.length = (in_data.prefix_length > MAX_LEN) ? MAX_LEN
                                                            : in_data.prefix_length;
  assign wr_route.port   = in_data.port_number;

  assign tok_w[0] = '{fwd_go, in_data.address, 1'b0, 6'd0, 8'd0, 32'h0};
  assign idx_w[0] = '0;

  assign tail    = tok_w[TABLE_ENTRIES];
  assign pkt_inc = (tail.packets == 32'hFFFF_FFFF) ? tail.packets : tail.packets + 32'd1;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      assign live[g] = (CNT_W'(g) < count_r);
      assign we[g]   = add_go && !full && (count_r == CNT_W'(g));
      assign upd[g]  = tail.valid && tail.found
                       && (idx_w[TABLE_ENTRIES] == IDX_W'(g));

      lpm_cell #(
        .IDX_W(IDX_W)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .live_i       (live[g]),
        .my_idx_i     (IDX_W'(g)),
        .we_i         (we[g]),
        .wr_i         (wr_route),
        .upd_i        (upd[g]),
        .upd_packets_i(pkt_inc),
        .tok_i        (tok_w[g]),
        .tok_idx_i    (idx_w[g]),
        .tok_o        (tok_w[g+1]),
        .tok_idx_o    (idx_w[g+1])
      );
    end
  endgenerate

  always_comb begin
    count_nxt     = count_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    if (add_go) begin
      out_valid_nxt = 1'b1;
      if (full) begin
        out_data_nxt.status = ST_FULL;
      end else begin
        out_data_nxt.status = ST_ADDED;
        count_nxt           = count_r + CNT_W'(1);
      end
    end else if (fwd_go) begin
      busy_nxt = 1'b1;
    end else if (tail.valid) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (tail.found) begin
        out_data_nxt.status       = ST_FORWARDED;
        out_data_nxt.out_port     = tail.port;
        out_data_nxt.match_length = tail.len;
        out_data_nxt.packets_seen = pkt_inc;
      end else begin
        out_data_nxt.status = ST_NO_ROUTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_out_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("result shown while busy");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> busy_r)
    else $error("search token in flight while idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_FULL)) |-> full)
    else $error("table full reported while entries free");
`endif

endmodule
